// ===== rtl/dtpg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtpg_pkg
// Shared types, codes and helpers for the send-on-delta publish gate.
// ----------------------------------------------------------------------------
package dtpg_pkg;

    localparam int TIME_BITS_DEF = 32;

    // request kinds carried on s_tuser
    localparam logic CMD_SAMPLE  = 1'b0;
    localparam logic CMD_OUTCOME = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HUM_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_THR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SOIL_THR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AIR_THR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RAIN_THR  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_PER = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN  = 3'd7;

    // bit positions of the result fields in m_tdata
    localparam int OUT_PUB_BIT    = 0;
    localparam int OUT_DELTA_BIT  = 1;
    localparam int OUT_FORCE_BIT  = 2;
    localparam int OUT_COMMIT_BIT = 3;
    localparam int OUT_W          = 8;
    localparam int IN_W           = 128;

    typedef struct packed {
        logic signed [14:0] temp;
        logic [13:0]        hum;
        logic [23:0]        press;
        logic [13:0]        soil;
        logic [2:0]         air;
        logic [2:0]         rain;
    } t_snap;

    // millivolts to whole volts, saturating at 7
    function automatic logic [2:0] to_volts(input logic [12:0] mv);
        logic [2:0] v;
        if (mv >= 13'd7000)      v = 3'd7;
        else if (mv >= 13'd6000) v = 3'd6;
        else if (mv >= 13'd5000) v = 3'd5;
        else if (mv >= 13'd4000) v = 3'd4;
        else if (mv >= 13'd3000) v = 3'd3;
        else if (mv >= 13'd2000) v = 3'd2;
        else if (mv >= 13'd1000) v = 3'd1;
        else                     v = 3'd0;
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/delta_triggered_publish_gate_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// delta_triggered_publish_gate_core
// Send-on-delta publish gate with forced period, cooldown and commit on ack.
// ----------------------------------------------------------------------------
// channel  | dir | handshake            | payload
// s_       | in  | s_tvalid / s_tready  | s_tdata sample fields, s_tuser kind
// m_       | out | m_tvalid / m_tready  | m_tdata four result flags
// cfg      | in  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One request per cycle while m_ is not stalled; a request passes the
// input register, then the result register, before its result is on m_.
// All state updates happen in the single pass between the two, so the next
// request sees them at once. A stalled m_ side holds the result and backs
// up through s_tready. Reset clears control state, last-sent values and
// stamps, and loads the default thresholds, force period and cooldown.
// ----------------------------------------------------------------------------
module delta_triggered_publish_gate_core
    import dtpg_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    // [14:0] temperature, [28:15] humidity, [52:29] pressure, [66:53] soil,
    // [79:67] air_mv, [92:80] rain_mv, [124:93] now_ms, [125] send_ok
    input  wire  [IN_W-1:0]      s_tdata,
    // [0] cmd
    input  wire                  s_tuser,
    output logic                 m_tvalid,
    input  wire                  m_tready,
    // [0] do_publish, [1] delta_hit, [2] force_hit, [3] committed
    output logic [OUT_W-1:0]     m_tdata,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [31:0]          i_cfg_data
);

    localparam int CMP_W = TIME_BITS + 32;

    // configuration
    logic [15:0] r_temp_thr;
    logic [13:0] r_hum_thr;
    logic [23:0] r_press_thr;
    logic [13:0] r_soil_thr;
    logic [2:0]  r_air_thr;
    logic [2:0]  r_rain_thr;
    logic [31:0] r_force_per;
    logic [31:0] r_cooldown;

    // pipeline
    logic         r_in_vld;
    logic         r_in_cmd;
    logic [125:0] r_in_data;
    logic         r_out_vld;
    logic [3:0]   r_out_flags;
    logic         advance;

    // state
    t_snap                r_sent;
    t_snap                r_pending;
    logic                 r_awaiting;
    logic [TIME_BITS-1:0] r_pub_time;
    logic [TIME_BITS-1:0] r_force_time;

    // single pass
    t_snap                snap;
    logic [CMP_W-1:0]     now_ext;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] force_diff;
    logic [TIME_BITS-1:0] pub_diff;
    logic signed [15:0]   temp_d;
    logic [15:0]          temp_abs;
    logic [13:0]          hum_abs;
    logic [23:0]          press_abs;
    logic [13:0]          soil_abs;
    logic [2:0]           air_abs;
    logic [2:0]           rain_abs;
    logic                 delta_hit;
    logic                 force_hit;
    logic                 cool_ok;
    logic                 pub;
    logic                 commit;
    logic [3:0]           n_out_flags;

    assign o_cfg_ready = 1'b1;
    assign advance     = !r_out_vld || m_tready;
    assign s_tready    = !r_in_vld || advance;
    assign m_tvalid    = r_out_vld;
    assign m_tdata     = {4'd0, r_out_flags};

    always_comb begin
        snap.temp  = r_in_data[14:0];
        snap.hum   = r_in_data[28:15];
        snap.press = r_in_data[52:29];
        snap.soil  = r_in_data[66:53];
        snap.air   = to_volts(r_in_data[79:67]);
        snap.rain  = to_volts(r_in_data[92:80]);
        now_ext    = {{TIME_BITS{1'b0}}, r_in_data[124:93]};
        now_t      = now_ext[TIME_BITS-1:0];

        temp_d    = {snap.temp[14], snap.temp} - {r_sent.temp[14], r_sent.temp};
        temp_abs  = temp_d[15] ? 16'(-temp_d) : 16'(temp_d);
        hum_abs   = (snap.hum >= r_sent.hum) ? snap.hum - r_sent.hum
                                             : r_sent.hum - snap.hum;
        press_abs = (snap.press >= r_sent.press) ? snap.press - r_sent.press
                                                 : r_sent.press - snap.press;
        soil_abs  = (snap.soil >= r_sent.soil) ? snap.soil - r_sent.soil
                                               : r_sent.soil - snap.soil;
        air_abs   = (snap.air >= r_sent.air) ? snap.air - r_sent.air
                                             : r_sent.air - snap.air;
        rain_abs  = (snap.rain >= r_sent.rain) ? snap.rain - r_sent.rain
                                               : r_sent.rain - snap.rain;

        force_diff = now_t - r_force_time;
        pub_diff   = now_t - r_pub_time;

        delta_hit = (r_in_cmd == CMD_SAMPLE) &&
                    ((temp_abs >= r_temp_thr) || (hum_abs >= r_hum_thr) ||
                     (press_abs >= r_press_thr) || (soil_abs >= r_soil_thr) ||
                     (air_abs >= r_air_thr) || (rain_abs >= r_rain_thr));
        force_hit = (r_in_cmd == CMD_SAMPLE) &&
                    ({{32{1'b0}}, force_diff} >= {{TIME_BITS{1'b0}}, r_force_per});
        cool_ok   = {{32{1'b0}}, pub_diff} >= {{TIME_BITS{1'b0}}, r_cooldown};
        pub       = (delta_hit || force_hit) && cool_ok;
        commit    = (r_in_cmd == CMD_OUTCOME) && r_awaiting && r_in_data[125];

        n_out_flags = '0;
        n_out_flags[OUT_PUB_BIT]    = pub;
        n_out_flags[OUT_DELTA_BIT]  = delta_hit;
        n_out_flags[OUT_FORCE_BIT]  = force_hit;
        n_out_flags[OUT_COMMIT_BIT] = commit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_awaiting   <= 1'b0;
            r_sent       <= '0;
            r_pub_time   <= '0;
            r_force_time <= '0;
            r_temp_thr   <= 16'd50;
            r_hum_thr    <= 14'd100;
            r_press_thr  <= 24'd10000;
            r_soil_thr   <= 14'd200;
            r_air_thr    <= 3'd1;
            r_rain_thr   <= 3'd1;
            r_force_per  <= 32'd60000;
            r_cooldown   <= 32'd1000;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_TEMP_THR:  r_temp_thr  <= i_cfg_data[15:0];
                    REG_HUM_THR:   r_hum_thr   <= i_cfg_data[13:0];
                    REG_PRESS_THR: r_press_thr <= i_cfg_data[23:0];
                    REG_SOIL_THR:  r_soil_thr  <= i_cfg_data[13:0];
                    REG_AIR_THR:   r_air_thr   <= i_cfg_data[2:0];
                    REG_RAIN_THR:  r_rain_thr  <= i_cfg_data[2:0];
                    REG_FORCE_PER: r_force_per <= i_cfg_data;
                    REG_COOLDOWN:  r_cooldown  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (s_tready) begin
                r_in_vld <= s_tvalid;
            end
            if (advance) begin
                r_out_vld <= r_in_vld;
            end
            // process the held request as it moves into the result register
            if (advance && r_in_vld) begin
                if (r_in_cmd == CMD_OUTCOME) begin
                    if (commit) begin
                        r_sent <= r_pending;
                    end
                    r_awaiting <= 1'b0;
                end else begin
                    if (force_hit) begin
                        r_force_time <= now_t;
                    end
                    if (pub) begin
                        r_awaiting <= 1'b1;
                        r_pub_time <= now_t;
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in_cmd  <= s_tuser;
            r_in_data <= s_tdata[125:0];
        end
        if (advance && r_in_vld) begin
            r_out_flags <= n_out_flags;
            if (pub) begin
                r_pending <= snap;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/dtpg_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtpg_checker
// Port-level checks on the publish gate, bound to the top level.
// ----------------------------------------------------------------------------
module dtpg_checker
    import dtpg_pkg::*;
(
    input wire             i_clk,
    input wire             i_rst_n,
    input wire             m_tvalid,
    input wire             m_tready,
    input wire [OUT_W-1:0] m_tdata
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a publish needs a reason
    a_pub_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[OUT_PUB_BIT] |->
            m_tdata[OUT_DELTA_BIT] || m_tdata[OUT_FORCE_BIT])
        else $error("publish without delta or force");

    // a commit comes from an outcome request, which carries no sample flags
    a_commit_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[OUT_COMMIT_BIT] |->
            !m_tdata[OUT_PUB_BIT] && !m_tdata[OUT_DELTA_BIT] &&
            !m_tdata[OUT_FORCE_BIT])
        else $error("commit mixed with sample flags");

    // reset drops any result
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind delta_triggered_publish_gate_core dtpg_checker u_dtpg_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
